// ===== rtl/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue package
// Field widths, transaction kind codes and the stored entry layout.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRI_W  = 2;
  localparam int unsigned WAIT_W = 16;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned CFG_W  = 16;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  localparam logic       CFG_LOW = 1'b0;
  localparam logic       CFG_MID = 1'b1;

  localparam logic [PRI_W-1:0]  PRI_NONE = 2'd0;
  localparam logic [PRI_W-1:0]  PRI_LOW  = 2'd1;
  localparam logic [PRI_W-1:0]  PRI_MID  = 2'd2;
  localparam logic [PRI_W-1:0]  PRI_HIGH = 2'd3;

  localparam logic [WAIT_W-1:0] PROMOTE_LOW_RESET = 16'd32;
  localparam logic [WAIT_W-1:0] PROMOTE_MID_RESET = 16'd128;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [WAIT_W-1:0] wait_t16;
  } entry_t;

endpackage

// ===== rtl/apq_in_if.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue request channel
// Valid/ready channel carrying insert, pop and tick requests.
// ----------------------------------------------------------------------------
interface apq_in_if
  import apq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   job_id;
  logic [PRI_W-1:0]  job_priority;
  logic [WAIT_W-1:0] start_wait;
  logic [WAIT_W-1:0] elapsed;

  modport source (output valid, kind, job_id, job_priority, start_wait, elapsed,
                  input ready);
  modport sink   (input valid, kind, job_id, job_priority, start_wait, elapsed,
                  output ready);
endinterface

// ===== rtl/apq_out_if.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue response channel
// Valid/ready channel carrying one response per request.
// ----------------------------------------------------------------------------
interface apq_out_if
  import apq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ID_W-1:0]   popped_id;
  logic [PRI_W-1:0]  popped_priority;
  logic [WAIT_W-1:0] popped_wait;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, ok, popped_id, popped_priority, popped_wait, occupancy,
                  input ready);
  modport sink   (input valid, ok, popped_id, popped_priority, popped_wait, occupancy,
                  output ready);
endinterface

// ===== rtl/aging_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue core
// Bounded job queue ordered by priority, first come first served within a
// priority, with wait ageing and promotion on every tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake    Contents
//  in_ch     sink       valid/ready  kind, job_id, job_priority, start_wait, elapsed
//  out_ch    source     valid/ready  ok, popped_id, popped_priority, popped_wait, occupancy
//  cfg       write      cfg_we_i     promotion thresholds
//
//  Jobs live in one memory with a registered read port; every step is a read,
//  then a compare or a write back. An insert moves back each job it passes; a
//  pop moves every held job one place forward; a tick ages each held job in
//  turn and moves it forward past lower priorities. A failed or unused request
//  goes straight to its response. A request is taken whenever the core is
//  idle; a finished response waits in its last state until the output register
//  is free. Reset empties the queue at once.
// ----------------------------------------------------------------------------
module aging_priority_queue_core
  import apq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  apq_in_if.sink           in_ch,
  apq_out_if.source        out_ch,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_TK_RD  = 8'b0000_0010,
    S_TK_AGE = 8'b0000_0100,
    S_SF_RD  = 8'b0000_1000,
    S_SF_CMP = 8'b0001_0000,
    S_PP_RD  = 8'b0010_0000,
    S_PP_WR  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  logic [WAIT_W-1:0] low_at_q, mid_at_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [IdxW-1:0]   j_q, j_d;
  entry_t            key_q, key_d;
  logic              is_tick_q, is_tick_d;
  logic [WAIT_W-1:0] elapsed_q, elapsed_d;

  logic              out_valid_q, out_valid_d;
  logic              res_ok_q, res_ok_d;
  entry_t            res_q, res_d;

  logic              out_load;
  logic              out_ok_q;
  entry_t            out_res_q;
  logic [CntW-1:0]   out_cnt_q;

  logic [WAIT_W:0]   aged_sum;
  logic [WAIT_W-1:0] aged_wait;
  entry_t            aged;

  // Ageing of the entry just read: saturating add, then at most one promotion.
  always_comb begin
    aged_sum  = {1'b0, rdata_q.wait_t16} + {1'b0, elapsed_q};
    aged_wait = aged_sum[WAIT_W] ? {WAIT_W{1'b1}} : aged_sum[WAIT_W-1:0];
    aged      = rdata_q;
    aged.wait_t16 = aged_wait;
    if (rdata_q.pri == PRI_LOW && aged_wait >= low_at_q) begin
      aged.pri = PRI_MID;
    end else if (rdata_q.pri == PRI_MID && aged_wait >= mid_at_q) begin
      aged.pri = PRI_HIGH;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    j_d         = j_q;
    key_d       = key_q;
    is_tick_d   = is_tick_q;
    elapsed_d   = elapsed_q;
    out_valid_d = out_valid_q;
    res_ok_d    = res_ok_q;
    res_d       = res_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = j_q;
    mem_raddr   = j_q;
    mem_wdata   = key_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_ok_d  = 1'b0;
          res_d     = '0;
          key_d.id  = in_ch.job_id;
          key_d.pri = in_ch.job_priority;
          key_d.wait_t16 = in_ch.start_wait;
          elapsed_d = in_ch.elapsed;
          k_d       = '0;
          is_tick_d = 1'b0;
          state_d   = S_DONE;
          case (in_ch.kind)
            KIND_INSERT: begin
              if (in_ch.job_priority != PRI_NONE && cnt_q != CntW'(QUEUE_DEPTH)) begin
                j_d     = cnt_q[IdxW-1:0];
                state_d = S_SF_RD;
              end
            end
            KIND_POP: begin
              if (cnt_q != '0) begin
                state_d = S_PP_RD;
              end
            end
            KIND_TICK: begin
              is_tick_d = 1'b1;
              res_ok_d  = 1'b1;
              state_d   = S_TK_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_TK_RD: begin
        if (k_q == cnt_q) begin
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_q[IdxW-1:0];
          state_d   = S_TK_AGE;
        end
      end
      S_TK_AGE: begin
        key_d   = aged;
        j_d     = k_q[IdxW-1:0];
        state_d = S_SF_RD;
      end
      // Insertion from the back: the hole moves forward past lower priorities.
      S_SF_RD: begin
        if (j_q == '0) begin
          mem_we = 1'b1;
          if (is_tick_q) begin
            k_d     = k_q + 1'b1;
            state_d = S_TK_RD;
          end else begin
            cnt_d    = cnt_q + 1'b1;
            res_ok_d = 1'b1;
            state_d  = S_DONE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = j_q - 1'b1;
          state_d   = S_SF_CMP;
        end
      end
      S_SF_CMP: begin
        mem_we = 1'b1;
        if (rdata_q.pri < key_q.pri) begin
          mem_wdata = rdata_q;
          j_d       = j_q - 1'b1;
          state_d   = S_SF_RD;
        end else if (is_tick_q) begin
          k_d     = k_q + 1'b1;
          state_d = S_TK_RD;
        end else begin
          cnt_d    = cnt_q + 1'b1;
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_PP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q[IdxW-1:0];
        state_d   = S_PP_WR;
      end
      S_PP_WR: begin
        if (k_q == '0) begin
          res_d    = rdata_q;
          res_ok_d = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = IdxW'(k_q - 1'b1);
          mem_wdata = rdata_q;
        end
        k_d = k_q + 1'b1;
        if (CntW'(k_q + 1'b1) == cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_PP_RD;
        end
      end
      S_DONE: begin
        // The response moves to the output register once that is free.
        if (!out_valid_q || out_ch.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      low_at_q    <= PROMOTE_LOW_RESET;
      mid_at_q    <= PROMOTE_MID_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == CFG_LOW) begin
        low_at_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_MID) begin
        mid_at_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    j_q       <= j_d;
    key_q     <= key_d;
    is_tick_q <= is_tick_d;
    elapsed_q <= elapsed_d;
    res_ok_q  <= res_ok_d;
    res_q     <= res_d;
    if (out_load) begin
      out_ok_q  <= res_ok_q;
      out_res_q <= res_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign in_ch.ready            = (state_q == S_IDLE);
  assign out_ch.valid           = out_valid_q;
  assign out_ch.ok              = out_ok_q;
  assign out_ch.popped_id       = out_res_q.id;
  assign out_ch.popped_priority = out_res_q.pri;
  assign out_ch.popped_wait     = out_res_q.wait_t16;
  assign out_ch.occupancy       = OCC_W'(out_cnt_q);

endmodule

// ===== tb/apq_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue testbench package
// Scoreboard that keeps its own copy of the job queue and predicts every
// response from the requests that the core has accepted.
// ----------------------------------------------------------------------------
package apq_tb_pkg;
  import apq_pkg::*;

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   popped_id;
    logic [PRI_W-1:0]  popped_priority;
    logic [WAIT_W-1:0] popped_wait;
    logic [OCC_W-1:0]  occupancy;
  } response_t;

  class job_scoreboard;
    entry_t            jobs[$];
    logic [WAIT_W-1:0] low_at;
    logic [WAIT_W-1:0] mid_at;
    response_t         pending[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      low_at     = PROMOTE_LOW_RESET;
      mid_at     = PROMOTE_MID_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_threshold(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_LOW) low_at = val;
      else mid_at = val;
    endfunction

    function int unsigned held();
      return jobs.size();
    endfunction

    // Works out the response to one accepted request and updates the queue.
    function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                               logic [PRI_W-1:0] pri, logic [WAIT_W-1:0] start,
                               logic [WAIT_W-1:0] elapsed);
      response_t r;
      entry_t    e;
      entry_t    sorted[$];
      int        pos;
      int        w;
      r = '0;
      if (kind == KIND_INSERT) begin
        if (pri != PRI_NONE && jobs.size() < DEPTH) begin
          pos = 0;
          while (pos < jobs.size() && jobs[pos].pri >= pri) pos++;
          e.id = id; e.pri = pri; e.wait_t16 = start;
          jobs.insert(pos, e);
          r.ok = 1'b1;
        end
      end else if (kind == KIND_POP) begin
        if (jobs.size() > 0) begin
          e = jobs.pop_front();
          r.ok = 1'b1;
          r.popped_id = e.id;
          r.popped_priority = e.pri;
          r.popped_wait = e.wait_t16;
        end
      end else if (kind == KIND_TICK) begin
        foreach (jobs[k]) begin
          w = int'(jobs[k].wait_t16) + int'(elapsed);
          if (w > 65535) w = 65535;
          jobs[k].wait_t16 = w[WAIT_W-1:0];
          if (jobs[k].pri == PRI_LOW && w >= int'(low_at)) jobs[k].pri = PRI_MID;
          else if (jobs[k].pri == PRI_MID && w >= int'(mid_at)) jobs[k].pri = PRI_HIGH;
        end
        // Stable regroup by priority, highest first.
        for (int p = 3; p >= 1; p--)
          foreach (jobs[k]) if (jobs[k].pri == p) sorted.push_back(jobs[k]);
        jobs = sorted;
        r.ok = 1'b1;
      end
      r.occupancy = OCC_W'(jobs.size());
      pending.push_back(r);
    endfunction

    function void check_response(response_t got);
      response_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Aging priority queue core testbench
// Drives directed and random insert, pop and tick transactions with random
// gaps and a long response stall, and checks every response field against a
// scoreboard that models the queue, across several threshold settings.
// ----------------------------------------------------------------------------
module testbench;
  import apq_pkg::*;
  import apq_tb_pkg::*;

  localparam int unsigned WATCHDOG = 20000;
  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_index_i = CFG_LOW;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             stall_long = 1'b0;
  int unsigned      idle_cycles = 0;
  int unsigned      sent = 0;
  int unsigned      ticks = 0;
  int unsigned      pops_ok = 0;
  job_scoreboard    sb;

  apq_in_if  in_ch();
  apq_out_if out_ch();

  aging_priority_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_INSERT;
    in_ch.job_id = '0;
    in_ch.job_priority = PRI_LOW;
    in_ch.start_wait = '0;
    in_ch.elapsed = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays high after an accept so that a following transaction can go
  // straight on; whoever stops sending drops it.
  task automatic send(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                      logic [PRI_W-1:0] pri, logic [WAIT_W-1:0] start,
                      logic [WAIT_W-1:0] elapsed, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.job_id <= id;
    in_ch.job_priority <= pri;
    in_ch.start_wait <= start;
    in_ch.elapsed <= elapsed;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(kind, id, pri, start, elapsed);
    sent++;
    if (kind == KIND_TICK) ticks++;
  endtask

  task automatic drain_and_configure(logic [CFG_W-1:0] low, logic [CFG_W-1:0] mid);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // Leave a quiet stretch before the thresholds change.
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_LOW;
    cfg_data_i <= low;
    @(posedge clk_i);
    sb.set_threshold(CFG_LOW, low);
    cfg_index_i <= CFG_MID;
    cfg_data_i <= mid;
    @(posedge clk_i);
    sb.set_threshold(CFG_MID, mid);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned roll;
    logic [PRI_W-1:0] pri;
    roll = $urandom_range(0, 99);
    pri = 2'($urandom_range(1, 3));
    if (roll < 3) pri = PRI_NONE;
    if (roll < 45)
      send(KIND_INSERT, 16'($urandom), pri,
           ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200)),
           16'($urandom), 1'b1);
    else if (roll < 75)
      send(KIND_POP, 16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    else if (roll < 97)
      send(KIND_TICK, 16'($urandom), 2'($urandom), 16'($urandom),
           ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)),
           1'b1);
    else
      send(KIND_RSVD, 16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom), 1'b1);
  endtask

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned g;
    response_t   r;
    @(posedge rst_ni);
    forever begin
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        stall_long = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        r.ok = out_ch.ok;
        r.popped_id = out_ch.popped_id;
        r.popped_priority = out_ch.popped_priority;
        r.popped_wait = out_ch.popped_wait;
        r.occupancy = out_ch.occupancy;
        if (r.ok && r.popped_priority != PRI_NONE) pops_ok++;
        sb.check_response(r);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, every kind, field extremes, full queue, saturation.
    send(KIND_POP, 16'hFFFF, PRI_HIGH, 16'hFFFF, 16'hFFFF, 1'b0);
    send(KIND_TICK, '0, PRI_NONE, '0, 16'h0000, 1'b0);
    send(KIND_INSERT, 16'h0000, PRI_NONE, 16'h1234, '0, 1'b0);
    send(KIND_INSERT, 16'hFFFF, PRI_HIGH, 16'hFFFF, 16'hFFFF, 1'b0);
    send(KIND_INSERT, 16'h0000, PRI_LOW, 16'h0000, '0, 1'b0);
    send(KIND_RSVD, 16'hAAAA, PRI_MID, 16'h5555, 16'hAAAA, 1'b0);
    for (int i = 0; i < 15; i++)
      send(KIND_INSERT, 16'(i + 16'h100), 2'(i % 3 + 1), 16'(i * 3), '0, 1'b0);
    send(KIND_TICK, '0, PRI_NONE, '0, 16'd40, 1'b0);
    send(KIND_TICK, '0, PRI_NONE, '0, 16'hFFFF, 1'b0);
    send(KIND_POP, '0, PRI_NONE, '0, '0, 1'b0);

    // Long hold-off on the response side while requests keep coming.
    stall_long = 1'b1;
    for (int i = 0; i < 30; i++) random_item();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: drain_and_configure(16'd0, 16'd0);
        1: drain_and_configure(16'hFFFF, 16'hFFFF);
        2: drain_and_configure(16'd16, 16'd64);
        3: drain_and_configure(16'd200, 16'd50);
        4: drain_and_configure(16'($urandom), 16'($urandom_range(0, 300)));
        default: drain_and_configure(PROMOTE_LOW_RESET, PROMOTE_MID_RESET);
      endcase
      for (int i = 0; i < 300; i++) random_item();
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d requests sent, %0d ticks, %0d successful pops, %0d responses checked",
             sent, ticks, pops_ok, sb.checked);
    $display("threshold settings covered: both extremes, reset values and random ones");
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
